[rtl/core/pdq_pkg.sv]
// Shared types, codes and defaults for the priority dispatch queue.
`default_nettype none

package pdq_pkg;

    // Default sizes
    localparam int PDQ_WAIT_DEPTH  = 16;
    localparam int PDQ_RUN_SLOTS   = 16;
    localparam int PDQ_PRIO_LEVELS = 16;

    // Fixed field widths
    localparam int TAG_W   = 8;
    localparam int PRIO_W  = 4;
    localparam int ORDER_W = 32;
    localparam int CMD_W   = 3;
    localparam int KIND_W  = 3;
    localparam int LIMIT_W = 5;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 3'd0,
        CMD_COMPLETE   = 3'd1,
        CMD_CANCEL_TAG = 3'd2,
        CMD_CANCEL_ALL = 3'd3,
        CMD_PAUSE      = 3'd4,
        CMD_RESUME     = 3'd5
    } cmd_t;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DISPATCH    = 3'd0,
        KIND_CANCEL_WAIT = 3'd1,
        KIND_CANCEL_RUN  = 3'd2,
        KIND_ACK         = 3'd3,
        KIND_REJECT      = 3'd4
    } kind_t;

    // Operations carried by a probe through the waiting chain
    typedef enum logic [1:0] {
        WOP_ADD = 2'd0,
        WOP_SEL = 2'd1,
        WOP_CLR = 2'd2,
        WOP_CAN = 2'd3
    } wait_op_t;

    // Operations carried by a probe through the active chain
    typedef enum logic [1:0] {
        ROP_COMP = 2'd0,
        ROP_INS  = 2'd1,
        ROP_CAN  = 2'd2
    } run_op_t;

    // Probe that walks the waiting chain, one cell per cycle
    typedef struct packed {
        logic                vld;
        wait_op_t            op;
        logic                hit;
        logic                all;
        logic [TAG_W-1:0]    tag;
        logic [PRIO_W-1:0]   prio;
        logic [ORDER_W-1:0]  order;
    } wprobe_t;

    // Probe that walks the active chain, one cell per cycle
    typedef struct packed {
        logic              vld;
        run_op_t           op;
        logic              hit;
        logic              all;
        logic [TAG_W-1:0]  tag;
    } rprobe_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_ADD,
        ST_R_COMP,
        ST_DISP_CHK,
        ST_W_SEL,
        ST_W_CLR,
        ST_R_INS,
        ST_EMIT_DISP,
        ST_R_CAN,
        ST_EMIT_CRUN,
        ST_W_CAN,
        ST_EMIT_CWAIT,
        ST_FINAL
    } pdq_state_t;

endpackage

`default_nettype wire

[rtl/core/priority_dispatch_queue_top.sv]
// Top level of the priority dispatch queue: sequencer plus two chains of table cells.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------------------
//  s_       | in        | s_valid / s_ready   | s_cmd, s_item_tag, s_priority_req
//  m_       | out       | m_valid / m_ready   | m_kind, m_out_tag, m_out_priority, m_last
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_data (max_active)
//
// Each table operation is a probe that walks its chain one cell per cycle, over the
// waiting table or the active table. An add or complete command takes one pass over its
// table; each dispatch adds a select pass and a clear pass over the waiting table and an
// insert pass over the active table; each cancel transaction takes one pass over its table.
// s_ready is high only between commands.
// Synchronous reset clears all valid bits at once; there is no clearing pass.
// A low m_ready holds the result register and stalls the sequencer; probes never stall.
`default_nettype none

module priority_dispatch_queue_top #(
    parameter int WAIT_DEPTH  = pdq_pkg::PDQ_WAIT_DEPTH,
    parameter int RUN_SLOTS   = pdq_pkg::PDQ_RUN_SLOTS,
    parameter int PRIO_LEVELS = pdq_pkg::PDQ_PRIO_LEVELS
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [pdq_pkg::CMD_W-1:0]     s_cmd,
    input  wire [pdq_pkg::TAG_W-1:0]     s_item_tag,
    input  wire [pdq_pkg::PRIO_W-1:0]    s_priority_req,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [pdq_pkg::KIND_W-1:0]   m_kind,
    output logic [pdq_pkg::TAG_W-1:0]    m_out_tag,
    output logic [pdq_pkg::PRIO_W-1:0]   m_out_priority,
    output logic                         m_last,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [pdq_pkg::LIMIT_W-1:0]   cfg_data
);
    import pdq_pkg::*;

    localparam int WIdxW = $clog2(WAIT_DEPTH);
    localparam int RIdxW = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;

    wprobe_t           wchain     [WAIT_DEPTH+1];
    logic [WIdxW-1:0]  wchain_idx [WAIT_DEPTH+1];
    rprobe_t           rchain     [RUN_SLOTS+1];
    logic [RIdxW-1:0]  rchain_idx [RUN_SLOTS+1];

    // Sequencer
    pdq_ctrl #(
        .WAIT_DEPTH  (WAIT_DEPTH),
        .RUN_SLOTS   (RUN_SLOTS),
        .PRIO_LEVELS (PRIO_LEVELS),
        .W_IDX_W     (WIdxW),
        .R_IDX_W     (RIdxW)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_item_tag     (s_item_tag),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_out_tag      (m_out_tag),
        .m_out_priority (m_out_priority),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .wlaunch        (wchain[0]),
        .wlaunch_idx    (wchain_idx[0]),
        .wexit          (wchain[WAIT_DEPTH]),
        .wexit_idx      (wchain_idx[WAIT_DEPTH]),
        .rlaunch        (rchain[0]),
        .rlaunch_idx    (rchain_idx[0]),
        .rexit          (rchain[RUN_SLOTS]),
        .rexit_idx      (rchain_idx[RUN_SLOTS])
    );

    // Waiting table: one cell per slot, slot 0 first in the chain
    for (genvar gi = 0; gi < WAIT_DEPTH; gi++) begin : g_wait
        pdq_wait_cell #(
            .IDX_W (WIdxW)
        ) u_wcell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (WIdxW'(gi)),
            .probe_in  (wchain[gi]),
            .idx_in    (wchain_idx[gi]),
            .probe_out (wchain[gi+1]),
            .idx_out   (wchain_idx[gi+1])
        );
    end

    // Active table: one cell per slot, slot 0 first in the chain
    for (genvar gr = 0; gr < RUN_SLOTS; gr++) begin : g_run
        pdq_run_cell #(
            .IDX_W (RIdxW)
        ) u_rcell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (RIdxW'(gr)),
            .probe_in  (rchain[gr]),
            .idx_in    (rchain_idx[gr]),
            .probe_out (rchain[gr+1]),
            .idx_out   (rchain_idx[gr+1])
        );
    end

endmodule

`default_nettype wire

[rtl/core/pdq_wait_cell.sv]
// One waiting-table entry with its stage of the waiting probe chain.
`default_nettype none

module pdq_wait_cell #(
    parameter int IDX_W = 4
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire [IDX_W-1:0]      cell_idx,
    input  pdq_pkg::wprobe_t     probe_in,
    input  wire [IDX_W-1:0]      idx_in,
    output pdq_pkg::wprobe_t     probe_out,
    output logic [IDX_W-1:0]     idx_out
);
    import pdq_pkg::*;

    logic                valid_reg, valid_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    wprobe_t             probe_reg, probe_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                better;
    logic                tag_match;

    // Rank this entry against the best seen so far: higher priority, then older
    assign better = (prio_reg > probe_in.prio) ||
                    ((prio_reg == probe_in.prio) && (order_reg < probe_in.order));
    assign tag_match = probe_in.all || (tag_reg == probe_in.tag);

    // Apply the probe's operation to this entry and pass it on
    always_comb begin
        probe_next = probe_in;
        idx_next   = idx_in;
        valid_next = valid_reg;
        tag_next   = tag_reg;
        prio_next  = prio_reg;
        order_next = order_reg;
        if (probe_in.vld) begin
            case (probe_in.op)
                WOP_ADD: begin
                    if (!probe_in.hit && !valid_reg) begin
                        valid_next     = 1'b1;
                        tag_next       = probe_in.tag;
                        prio_next      = probe_in.prio;
                        order_next     = probe_in.order;
                        probe_next.hit = 1'b1;
                    end
                end
                WOP_SEL: begin
                    if (valid_reg && (!probe_in.hit || better)) begin
                        probe_next.hit   = 1'b1;
                        probe_next.tag   = tag_reg;
                        probe_next.prio  = prio_reg;
                        probe_next.order = order_reg;
                        idx_next         = cell_idx;
                    end
                end
                WOP_CLR: begin
                    if (idx_in == cell_idx) begin
                        valid_next = 1'b0;
                    end
                end
                WOP_CAN: begin
                    if (!probe_in.hit && valid_reg && (idx_in <= cell_idx) && tag_match) begin
                        valid_next      = 1'b0;
                        probe_next.hit  = 1'b1;
                        probe_next.tag  = tag_reg;
                        probe_next.prio = prio_reg;
                        idx_next        = cell_idx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold entry valid bit and probe stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            probe_reg <= probe_next;
        end
    end

    // Entry payload and probe index need no reset
    always_ff @(posedge aclk) begin
        tag_reg   <= tag_next;
        prio_reg  <= prio_next;
        order_reg <= order_next;
        idx_reg   <= idx_next;
    end

    assign probe_out = probe_reg;
    assign idx_out   = idx_reg;

endmodule

`default_nettype wire

[rtl/core/pdq_run_cell.sv]
// One active-table entry with its stage of the active probe chain.
`default_nettype none

module pdq_run_cell #(
    parameter int IDX_W = 4
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire [IDX_W-1:0]      cell_idx,
    input  pdq_pkg::rprobe_t     probe_in,
    input  wire [IDX_W-1:0]      idx_in,
    output pdq_pkg::rprobe_t     probe_out,
    output logic [IDX_W-1:0]     idx_out
);
    import pdq_pkg::*;

    logic              valid_reg, valid_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    rprobe_t           probe_reg, probe_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              tag_match;

    assign tag_match = probe_in.all || (tag_reg == probe_in.tag);

    // Apply the probe's operation to this entry and pass it on
    always_comb begin
        probe_next = probe_in;
        idx_next   = idx_in;
        valid_next = valid_reg;
        tag_next   = tag_reg;
        if (probe_in.vld) begin
            case (probe_in.op)
                ROP_COMP: begin
                    if (!probe_in.hit && valid_reg && (tag_reg == probe_in.tag)) begin
                        valid_next     = 1'b0;
                        probe_next.hit = 1'b1;
                    end
                end
                ROP_INS: begin
                    if (!probe_in.hit && !valid_reg) begin
                        valid_next     = 1'b1;
                        tag_next       = probe_in.tag;
                        probe_next.hit = 1'b1;
                    end
                end
                ROP_CAN: begin
                    // Report only; the item stays active
                    if (!probe_in.hit && valid_reg && (idx_in <= cell_idx) && tag_match) begin
                        probe_next.hit = 1'b1;
                        probe_next.tag = tag_reg;
                        idx_next       = cell_idx;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Hold entry valid bit and probe stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            probe_reg <= '0;
        end else begin
            valid_reg <= valid_next;
            probe_reg <= probe_next;
        end
    end

    // Entry tag and probe index need no reset
    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
        idx_reg <= idx_next;
    end

    assign probe_out = probe_reg;
    assign idx_out   = idx_reg;

endmodule

`default_nettype wire

[rtl/core/pdq_ctrl.sv]
// Command sequencer: launches probes, tracks counters, drives the result register.
`default_nettype none

module pdq_ctrl #(
    parameter int WAIT_DEPTH  = pdq_pkg::PDQ_WAIT_DEPTH,
    parameter int RUN_SLOTS   = pdq_pkg::PDQ_RUN_SLOTS,
    parameter int PRIO_LEVELS = pdq_pkg::PDQ_PRIO_LEVELS,
    parameter int W_IDX_W     = 4,
    parameter int R_IDX_W     = 4
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // Command channel
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire [pdq_pkg::CMD_W-1:0]     s_cmd,
    input  wire [pdq_pkg::TAG_W-1:0]     s_item_tag,
    input  wire [pdq_pkg::PRIO_W-1:0]    s_priority_req,
    // Result channel
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [pdq_pkg::KIND_W-1:0]   m_kind,
    output logic [pdq_pkg::TAG_W-1:0]    m_out_tag,
    output logic [pdq_pkg::PRIO_W-1:0]   m_out_priority,
    output logic                         m_last,
    // Limit register write
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [pdq_pkg::LIMIT_W-1:0]   cfg_data,
    // Probe chains
    output pdq_pkg::wprobe_t             wlaunch,
    output logic [W_IDX_W-1:0]           wlaunch_idx,
    input  pdq_pkg::wprobe_t             wexit,
    input  wire [W_IDX_W-1:0]            wexit_idx,
    output pdq_pkg::rprobe_t             rlaunch,
    output logic [R_IDX_W-1:0]           rlaunch_idx,
    input  pdq_pkg::rprobe_t             rexit,
    input  wire [R_IDX_W-1:0]            rexit_idx
);
    import pdq_pkg::*;

    localparam int RunCntW = $clog2(RUN_SLOTS + 1);
    localparam int LimW    = (RunCntW > LIMIT_W) ? RunCntW : LIMIT_W;
    localparam int PrioMax = PRIO_LEVELS - 1;

    pdq_state_t           state_reg, state_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [PRIO_W-1:0]    prio_reg, prio_next;
    logic                 all_reg, all_next;
    logic                 paused_reg, paused_next;
    logic [RunCntW-1:0]   run_count_reg, run_count_next;
    logic [ORDER_W-1:0]   order_reg, order_next;
    logic [LIMIT_W-1:0]   max_active_reg;
    logic [TAG_W-1:0]     best_tag_reg, best_tag_next;
    logic [PRIO_W-1:0]    best_prio_reg, best_prio_next;
    logic [W_IDX_W-1:0]   widx_reg, widx_next;
    logic [R_IDX_W-1:0]   ridx_reg, ridx_next;
    kind_t                fin_kind_reg, fin_kind_next;
    logic [PRIO_W-1:0]    fin_prio_reg, fin_prio_next;

    logic                 m_valid_reg;
    kind_t                m_kind_reg;
    logic [TAG_W-1:0]     m_tag_reg;
    logic [PRIO_W-1:0]    m_prio_reg;
    logic                 m_last_reg;

    logic                 out_free;
    logic                 out_load;
    kind_t                out_kind;
    logic [TAG_W-1:0]     out_tag;
    logic [PRIO_W-1:0]    out_prio;
    logic                 out_last;
    logic [PRIO_W-1:0]    prio_sat;
    logic [LimW-1:0]      limit;
    logic                 at_limit;
    logic                 run_last;
    logic                 wait_last;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign run_last  = (ridx_reg == R_IDX_W'(RUN_SLOTS - 1));
    assign wait_last = (widx_reg == W_IDX_W'(WAIT_DEPTH - 1));

    // Saturate the requested priority to the supported range
    assign prio_sat = (int'(s_priority_req) > PrioMax) ? PRIO_W'(PrioMax) : s_priority_req;

    // Clamp the limit register into 1..RUN_SLOTS
    always_comb begin
        if (max_active_reg == '0) begin
            limit = LimW'(1);
        end else if (LimW'(max_active_reg) > LimW'(RUN_SLOTS)) begin
            limit = LimW'(RUN_SLOTS);
        end else begin
            limit = LimW'(max_active_reg);
        end
    end
    assign at_limit = (LimW'(run_count_reg) >= limit);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (cmd_t'(s_cmd))
                        CMD_ADD:        state_next = ST_W_ADD;
                        CMD_COMPLETE:   state_next = ST_R_COMP;
                        CMD_CANCEL_TAG: state_next = ST_R_CAN;
                        CMD_CANCEL_ALL: state_next = ST_R_CAN;
                        CMD_RESUME:     state_next = ST_DISP_CHK;
                        default:        state_next = ST_FINAL;
                    endcase
                end
            end
            ST_W_ADD: begin
                if (wexit.vld) state_next = wexit.hit ? ST_DISP_CHK : ST_FINAL;
            end
            ST_R_COMP: begin
                if (rexit.vld) state_next = rexit.hit ? ST_DISP_CHK : ST_FINAL;
            end
            ST_DISP_CHK: begin
                state_next = (paused_reg || at_limit) ? ST_FINAL : ST_W_SEL;
            end
            ST_W_SEL: begin
                if (wexit.vld) state_next = wexit.hit ? ST_W_CLR : ST_FINAL;
            end
            ST_W_CLR: begin
                if (wexit.vld) state_next = ST_R_INS;
            end
            ST_R_INS: begin
                if (rexit.vld) state_next = ST_EMIT_DISP;
            end
            ST_EMIT_DISP: begin
                if (out_free) state_next = ST_DISP_CHK;
            end
            ST_R_CAN: begin
                if (rexit.vld) state_next = rexit.hit ? ST_EMIT_CRUN : ST_W_CAN;
            end
            ST_EMIT_CRUN: begin
                if (out_free) state_next = run_last ? ST_W_CAN : ST_R_CAN;
            end
            ST_W_CAN: begin
                if (wexit.vld) state_next = wexit.hit ? ST_EMIT_CWAIT : ST_FINAL;
            end
            ST_EMIT_CWAIT: begin
                if (out_free) state_next = wait_last ? ST_FINAL : ST_W_CAN;
            end
            ST_FINAL: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Probe launches, result loads and datapath updates
    always_comb begin
        wlaunch        = '0;
        wlaunch_idx    = '0;
        rlaunch        = '0;
        rlaunch_idx    = '0;
        out_load       = 1'b0;
        out_kind       = KIND_ACK;
        out_tag        = tag_reg;
        out_prio       = '0;
        out_last       = 1'b0;
        tag_next       = tag_reg;
        prio_next      = prio_reg;
        all_next       = all_reg;
        paused_next    = paused_reg;
        run_count_next = run_count_reg;
        order_next     = order_reg;
        best_tag_next  = best_tag_reg;
        best_prio_next = best_prio_reg;
        widx_next      = widx_reg;
        ridx_next      = ridx_reg;
        fin_kind_next  = fin_kind_reg;
        fin_prio_next  = fin_prio_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    tag_next      = s_item_tag;
                    prio_next     = prio_sat;
                    all_next      = (s_cmd == CMD_CANCEL_ALL);
                    fin_kind_next = KIND_ACK;
                    fin_prio_next = '0;
                    case (cmd_t'(s_cmd))
                        CMD_ADD: begin
                            wlaunch.vld   = 1'b1;
                            wlaunch.op    = WOP_ADD;
                            wlaunch.tag   = s_item_tag;
                            wlaunch.prio  = prio_sat;
                            wlaunch.order = order_reg;
                        end
                        CMD_COMPLETE: begin
                            rlaunch.vld = 1'b1;
                            rlaunch.op  = ROP_COMP;
                            rlaunch.tag = s_item_tag;
                        end
                        CMD_CANCEL_TAG, CMD_CANCEL_ALL: begin
                            rlaunch.vld = 1'b1;
                            rlaunch.op  = ROP_CAN;
                            rlaunch.tag = s_item_tag;
                            rlaunch.all = (s_cmd == CMD_CANCEL_ALL);
                        end
                        CMD_PAUSE:  paused_next = 1'b1;
                        CMD_RESUME: paused_next = 1'b0;
                        default:    fin_kind_next = KIND_REJECT;
                    endcase
                end
            end
            ST_W_ADD: begin
                if (wexit.vld) begin
                    if (wexit.hit) begin
                        order_next = order_reg + ORDER_W'(1);
                    end else begin
                        // Table full: reject and keep the priority
                        fin_kind_next = KIND_REJECT;
                        fin_prio_next = prio_reg;
                    end
                end
            end
            ST_R_COMP: begin
                if (rexit.vld) begin
                    if (rexit.hit) begin
                        if (run_count_reg != '0) run_count_next = run_count_reg - RunCntW'(1);
                    end else begin
                        fin_kind_next = KIND_REJECT;
                    end
                end
            end
            ST_DISP_CHK: begin
                if (!paused_reg && !at_limit) begin
                    wlaunch.vld = 1'b1;
                    wlaunch.op  = WOP_SEL;
                end
            end
            ST_W_SEL: begin
                // Winner known: sweep again to drop it from the waiting table
                if (wexit.vld && wexit.hit) begin
                    best_tag_next  = wexit.tag;
                    best_prio_next = wexit.prio;
                    wlaunch.vld    = 1'b1;
                    wlaunch.op     = WOP_CLR;
                    wlaunch_idx    = wexit_idx;
                end
            end
            ST_W_CLR: begin
                if (wexit.vld) begin
                    rlaunch.vld = 1'b1;
                    rlaunch.op  = ROP_INS;
                    rlaunch.tag = best_tag_reg;
                end
            end
            ST_R_INS: begin
                if (rexit.vld) run_count_next = run_count_reg + RunCntW'(1);
            end
            ST_EMIT_DISP: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_DISPATCH;
                    out_tag  = best_tag_reg;
                    out_prio = best_prio_reg;
                end
            end
            ST_R_CAN: begin
                if (rexit.vld) begin
                    if (rexit.hit) begin
                        best_tag_next = rexit.tag;
                        ridx_next     = rexit_idx;
                    end else begin
                        wlaunch.vld = 1'b1;
                        wlaunch.op  = WOP_CAN;
                        wlaunch.tag = tag_reg;
                        wlaunch.all = all_reg;
                    end
                end
            end
            ST_EMIT_CRUN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_CANCEL_RUN;
                    out_tag  = best_tag_reg;
                    // Resume the active sweep past this slot, or start on waiting items
                    if (run_last) begin
                        wlaunch.vld = 1'b1;
                        wlaunch.op  = WOP_CAN;
                        wlaunch.tag = tag_reg;
                        wlaunch.all = all_reg;
                    end else begin
                        rlaunch.vld = 1'b1;
                        rlaunch.op  = ROP_CAN;
                        rlaunch.tag = tag_reg;
                        rlaunch.all = all_reg;
                        rlaunch_idx = ridx_reg + R_IDX_W'(1);
                    end
                end
            end
            ST_W_CAN: begin
                if (wexit.vld && wexit.hit) begin
                    best_tag_next  = wexit.tag;
                    best_prio_next = wexit.prio;
                    widx_next      = wexit_idx;
                end
            end
            ST_EMIT_CWAIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_CANCEL_WAIT;
                    out_tag  = best_tag_reg;
                    out_prio = best_prio_reg;
                    if (!wait_last) begin
                        wlaunch.vld = 1'b1;
                        wlaunch.op  = WOP_CAN;
                        wlaunch.tag = tag_reg;
                        wlaunch.all = all_reg;
                        wlaunch_idx = widx_reg + W_IDX_W'(1);
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = fin_kind_reg;
                    out_tag  = tag_reg;
                    out_prio = fin_prio_reg;
                    out_last = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            paused_reg     <= 1'b0;
            run_count_reg  <= '0;
            order_reg      <= '0;
            max_active_reg <= LIMIT_W'(1);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            paused_reg    <= paused_next;
            run_count_reg <= run_count_next;
            order_reg     <= order_next;
            if (cfg_valid) max_active_reg <= cfg_data;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Command operands and held results
    always_ff @(posedge aclk) begin
        tag_reg       <= tag_next;
        prio_reg      <= prio_next;
        all_reg       <= all_next;
        best_tag_reg  <= best_tag_next;
        best_prio_reg <= best_prio_next;
        widx_reg      <= widx_next;
        ridx_reg      <= ridx_next;
        fin_kind_reg  <= fin_kind_next;
        fin_prio_reg  <= fin_prio_next;
        if (out_load) begin
            m_kind_reg <= out_kind;
            m_tag_reg  <= out_tag;
            m_prio_reg <= out_prio;
            m_last_reg <= out_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_out_tag      = m_tag_reg;
    assign m_out_priority = m_prio_reg;
    assign m_last         = m_last_reg;

`ifndef SYNTH
    // No probe may be in flight between commands
    a_idle_no_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!wexit.vld && !rexit.vld))
        else $error("probe left a chain while the sequencer was idle");

    // Active count never exceeds the number of slots
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(run_count_reg) <= RUN_SLOTS))
        else $error("active count above slot count");

    // A dispatch transaction is never presented while paused
    a_disp_unpaused: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg == KIND_DISPATCH)) |-> !paused_reg)
        else $error("dispatch presented while paused");

    // One command at a time: accept drops ready on the next cycle
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second command accepted back to back");
`endif

endmodule

`default_nettype wire

[tb/pdq_dispatch_checker.sv]
// Result checker for the priority dispatch queue: predicts every result and compares on m_.
module pdq_dispatch_checker (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         s_valid,
    input  wire                         s_ready,
    input  wire [pdq_pkg::CMD_W-1:0]    s_cmd,
    input  wire [pdq_pkg::TAG_W-1:0]    s_item_tag,
    input  wire [pdq_pkg::PRIO_W-1:0]   s_priority_req,
    input  wire                         m_valid,
    input  wire                         m_ready,
    input  wire [pdq_pkg::KIND_W-1:0]   m_kind,
    input  wire [pdq_pkg::TAG_W-1:0]    m_out_tag,
    input  wire [pdq_pkg::PRIO_W-1:0]   m_out_priority,
    input  wire                         m_last,
    input  wire                         cfg_valid,
    input  wire                         cfg_ready,
    input  wire [pdq_pkg::LIMIT_W-1:0]  cfg_data,
    output int                          fail_count,
    output int                          pending
);
    import pdq_pkg::*;

    localparam int WAIT_N      = PDQ_WAIT_DEPTH;
    localparam int RUN_N       = PDQ_RUN_SLOTS;
    localparam int PRIO_MAX    = PDQ_PRIO_LEVELS - 1;
    localparam int MAX_REPORTS = 100;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic              last;
    } pdq_result_t;

    // Predicted contents of the waiting and active tables
    logic               waiting      [WAIT_N];
    logic [TAG_W-1:0]   waiting_tag  [WAIT_N];
    logic [PRIO_W-1:0]  waiting_prio [WAIT_N];
    logic [ORDER_W-1:0] waiting_seq  [WAIT_N];
    logic               active       [RUN_N];
    logic [TAG_W-1:0]   active_tag   [RUN_N];
    int                 active_count;
    logic               held;
    logic [ORDER_W-1:0] seq_next;
    logic [LIMIT_W-1:0] limit_reg;

    pdq_result_t due_results[$];
    int          mismatches;

    function automatic void clear_tables();
        for (int w = 0; w < WAIT_N; w++) waiting[w] = 1'b0;
        for (int r = 0; r < RUN_N; r++) active[r] = 1'b0;
        active_count = 0;
        held         = 1'b0;
        seq_next     = '0;
        limit_reg    = LIMIT_W'(1);
        mismatches   = 0;
        due_results.delete();
    endfunction

    function automatic void post(kind_t kind, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio,
                                 logic last);
        pdq_result_t r;
        r.kind = kind;
        r.tag  = tag;
        r.prio = prio;
        r.last = last;
        due_results.push_back(r);
    endfunction

    // Clamp the limit register to 1..RUN_N
    function automatic int effective_limit();
        if (limit_reg == '0) return 1;
        if (int'(limit_reg) > RUN_N) return RUN_N;
        return int'(limit_reg);
    endfunction

    // Move the best waiting item into the lowest free active slot until blocked
    function automatic void dispatch_ready();
        int best;
        int slot;
        while (!held && active_count < effective_limit()) begin
            best = -1;
            slot = -1;
            for (int w = 0; w < WAIT_N; w++) begin
                if (waiting[w] && (best < 0 || waiting_prio[w] > waiting_prio[best] ||
                    (waiting_prio[w] == waiting_prio[best] &&
                     waiting_seq[w] < waiting_seq[best])))
                    best = w;
            end
            for (int r = RUN_N - 1; r >= 0; r--) begin
                if (!active[r]) slot = r;
            end
            if (best < 0 || slot < 0) break;
            waiting[best]    = 1'b0;
            active[slot]     = 1'b1;
            active_tag[slot] = waiting_tag[best];
            active_count++;
            post(KIND_DISPATCH, waiting_tag[best], waiting_prio[best], 1'b0);
        end
    endfunction

    // Update the tables for one accepted command and queue the results it causes
    function automatic void apply_command(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
                                          logic [PRIO_W-1:0] prio_in);
        logic [PRIO_W-1:0] prio;
        int slot;
        prio = (int'(prio_in) > PRIO_MAX) ? PRIO_W'(PRIO_MAX) : prio_in;
        slot = -1;
        case (cmd)
            CMD_ADD: begin
                for (int w = WAIT_N - 1; w >= 0; w--) begin
                    if (!waiting[w]) slot = w;
                end
                if (slot < 0) begin
                    post(KIND_REJECT, tag, prio, 1'b1);
                end else begin
                    waiting[slot]      = 1'b1;
                    waiting_tag[slot]  = tag;
                    waiting_prio[slot] = prio;
                    waiting_seq[slot]  = seq_next;
                    seq_next++;
                    dispatch_ready();
                    post(KIND_ACK, tag, '0, 1'b1);
                end
            end
            CMD_COMPLETE: begin
                for (int r = RUN_N - 1; r >= 0; r--) begin
                    if (active[r] && active_tag[r] == tag) slot = r;
                end
                if (slot < 0) begin
                    post(KIND_REJECT, tag, '0, 1'b1);
                end else begin
                    active[slot] = 1'b0;
                    if (active_count > 0) active_count--;
                    dispatch_ready();
                    post(KIND_ACK, tag, '0, 1'b1);
                end
            end
            CMD_CANCEL_TAG, CMD_CANCEL_ALL: begin
                // report active matches (they stay), then drop waiting matches
                for (int r = 0; r < RUN_N; r++) begin
                    if (active[r] && (cmd == CMD_CANCEL_ALL || active_tag[r] == tag))
                        post(KIND_CANCEL_RUN, active_tag[r], '0, 1'b0);
                end
                for (int w = 0; w < WAIT_N; w++) begin
                    if (waiting[w] && (cmd == CMD_CANCEL_ALL || waiting_tag[w] == tag)) begin
                        waiting[w] = 1'b0;
                        post(KIND_CANCEL_WAIT, waiting_tag[w], waiting_prio[w], 1'b0);
                    end
                end
                post(KIND_ACK, tag, '0, 1'b1);
            end
            CMD_PAUSE: begin
                held = 1'b1;
                post(KIND_ACK, tag, '0, 1'b1);
            end
            CMD_RESUME: begin
                held = 1'b0;
                dispatch_ready();
                post(KIND_ACK, tag, '0, 1'b1);
            end
            default: begin
                post(KIND_REJECT, tag, '0, 1'b1);
            end
        endcase
    endfunction

    // Compare one accepted result against the oldest prediction
    function automatic void check_result();
        pdq_result_t want;
        pdq_result_t got;
        got.kind = m_kind;
        got.tag  = m_out_tag;
        got.prio = m_out_priority;
        got.last = m_last;
        if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: unexpected result: expected none, actual kind=%0d tag=%0d",
                         $time, got.kind, got.tag, " prio=%0d last=%0d", got.prio, got.last);
        end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.tag !== want.tag ||
                got.prio !== want.prio || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result mismatch: expected kind=%0d tag=%0d prio=%0d last=%0d",
                             $time, want.kind, want.tag, want.prio, want.last,
                             ", actual kind=%0d tag=%0d prio=%0d last=%0d",
                             got.kind, got.tag, got.prio, got.last);
            end
        end
    endfunction

    // Retire the output transaction first: it always belongs to an earlier command
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_tables();
        end else begin
            if (m_valid && m_ready) check_result();
            if (cfg_valid && cfg_ready) limit_reg = cfg_data;
            if (s_valid && s_ready) apply_command(s_cmd, s_item_tag, s_priority_req);
        end
        fail_count <= mismatches;
        pending    <= due_results.size();
    end

endmodule

[tb/tb_top.sv]
// Testbench top: drives commands and limit writes into the queue and gives the verdict.
module tb_top;
    import pdq_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 100;
    localparam int PHASE_ITEMS   = 12;

    // Command codes the block does not define
    localparam logic [CMD_W-1:0] CMD_BAD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_BAD_HI = 3'd7;

    logic               aclk;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [CMD_W-1:0]   s_cmd          = '0;
    logic [TAG_W-1:0]   s_item_tag     = '0;
    logic [PRIO_W-1:0]  s_priority_req = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [KIND_W-1:0]  m_kind;
    logic [TAG_W-1:0]   m_out_tag;
    logic [PRIO_W-1:0]  m_out_priority;
    logic               m_last;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data       = '0;
    int                 fail_count;
    int                 pending;

    logic [TAG_W-1:0]   running_tags[$];
    int                 burst_left     = 0;
    logic [15:0]        stall_pattern  = '1;
    int                 stall_phase    = 0;

    priority_dispatch_queue_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_item_tag     (s_item_tag),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_out_tag      (m_out_tag),
        .m_out_priority (m_out_priority),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    pdq_dispatch_checker results_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_item_tag     (s_item_tag),
        .s_priority_req (s_priority_req),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_out_tag      (m_out_tag),
        .m_out_priority (m_out_priority),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Stall the result channel on a random pattern that is picked anew whenever stall_phase wraps
    always @(posedge aclk) begin
        if (stall_phase == 63) begin
            case ($urandom_range(0, 3))
                0:       stall_pattern <= '1;
                1:       stall_pattern <= 16'($urandom);
                2:       stall_pattern <= 16'($urandom) | 16'($urandom);
                default: stall_pattern <= 16'hFF00;
            endcase
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
        end
        m_ready <= stall_pattern[stall_phase % 16];
    end

    // Record dispatched tags on the falling edge so completes mostly name an active item
    always @(negedge aclk) begin
        if (aresetn && m_valid && m_ready && m_kind == KIND_DISPATCH)
            running_tags.push_back(m_out_tag);
    end

    // Present one command, idling first when the current burst is used up
    task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [TAG_W-1:0] tag,
                                 input logic [PRIO_W-1:0] prio);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            // mostly short bursts, now and then a long run with no idle cycles
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_item_tag     <= tag;
        s_priority_req <= prio;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold the sender until every predicted result has been seen
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Small tag pool so duplicates and cancel matches are common
    function automatic logic [TAG_W-1:0] pool_tag();
        if ($urandom_range(0, 3) == 0) return TAG_W'($urandom_range(0, 255));
        return {(($urandom_range(0, 1) != 0) ? 4'hF : 4'h0), 4'($urandom_range(0, 15))};
    endfunction

    task automatic random_item();
        int pick;
        int idx;
        logic [TAG_W-1:0] tag;
        pick = $urandom_range(0, 99);
        tag  = pool_tag();
        if (pick < 40) begin
            offer_command(CMD_ADD, tag, PRIO_W'($urandom_range(0, 15)));
        end else if (pick < 70) begin
            // complete an active tag most of the time, a random one otherwise
            if (running_tags.size() != 0 && $urandom_range(0, 9) != 0) begin
                idx = $urandom_range(0, running_tags.size() - 1);
                tag = running_tags[idx];
                running_tags.delete(idx);
            end
            offer_command(CMD_COMPLETE, tag, PRIO_W'($urandom));
        end else if (pick < 78) begin
            offer_command(CMD_CANCEL_TAG, tag, PRIO_W'($urandom));
        end else if (pick < 81) begin
            offer_command(CMD_CANCEL_ALL, tag, PRIO_W'($urandom));
        end else if (pick < 87) begin
            offer_command(CMD_PAUSE, tag, PRIO_W'($urandom));
        end else if (pick < 95) begin
            offer_command(CMD_RESUME, tag, PRIO_W'($urandom));
        end else begin
            offer_command(($urandom_range(0, 1) != 0) ? CMD_BAD_HI : CMD_BAD_LO, tag,
                          PRIO_W'($urandom));
        end
    endtask

    // Empty both tables, fill them to capacity, then cancel everything in one command
    task automatic run_full_tables();
        offer_command(CMD_RESUME, pool_tag(), '0);
        offer_command(CMD_CANCEL_ALL, pool_tag(), '0);
        wait_drained();
        while (running_tags.size() != 0)
            offer_command(CMD_COMPLETE, running_tags.pop_front(), '0);
        for (int n = 0; n < 2 * PDQ_RUN_SLOTS; n++)
            offer_command(CMD_ADD, pool_tag(), PRIO_W'($urandom));
        offer_command(CMD_CANCEL_ALL, pool_tag(), PRIO_W'($urandom));
    endtask

    initial begin
        logic [LIMIT_W-1:0] limit_plan [5];
        limit_plan[0] = LIMIT_W'(PDQ_RUN_SLOTS);
        limit_plan[1] = '0;
        limit_plan[2] = '1;
        limit_plan[3] = LIMIT_W'($urandom_range(2, 15));
        limit_plan[4] = LIMIT_W'(1);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the waiting table while paused, with equal priorities and a duplicate tag
        offer_command(CMD_PAUSE, 8'h00, 4'h0);
        offer_command(CMD_ADD, 8'h00, 4'h0);
        offer_command(CMD_ADD, 8'hFF, 4'hF);
        offer_command(CMD_ADD, 8'h5A, 4'h7);
        offer_command(CMD_ADD, 8'hA5, 4'hF);
        for (int j = 4; j < PDQ_WAIT_DEPTH; j++)
            offer_command(CMD_ADD, 8'(j * 17), 4'(j));
        // table full: the add is rejected
        offer_command(CMD_ADD, 8'h77, 4'h9);
        offer_command(CMD_CANCEL_TAG, 8'h5A, 4'h0);
        offer_command(CMD_BAD_LO, 8'h12, 4'h3);
        offer_command(CMD_BAD_HI, 8'hED, 4'hC);
        offer_command(CMD_RESUME, 8'h01, 4'h0);
        wait_drained();
        offer_command(CMD_COMPLETE, running_tags.pop_front(), 4'h0);
        // complete of a tag that is not active
        offer_command(CMD_COMPLETE, 8'h33, 4'h0);
        // cancel an active item twice, then a cancel that matches nothing
        offer_command(CMD_CANCEL_TAG, 8'hA5, 4'h0);
        offer_command(CMD_CANCEL_TAG, 8'hA5, 4'h5);
        offer_command(CMD_CANCEL_TAG, 8'h33, 4'h0);

        // Random phases, each under its own limit; all ones is above range
        for (int p = 0; p < 5; p++) begin
            write_limit(limit_plan[p]);
            if (limit_plan[p] == '1) run_full_tables();
            repeat (PHASE_ITEMS) random_item();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // End a hung run
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
